[src/assert_macros.svh]
// Assertion helpers for the RTL; plc_core.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, masked while reset is high.
`define PLC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define PLC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PLC_ASSERT(lbl, clk, rst, prop, msg)
`define PLC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[src/plc_pkg.sv]
`default_nettype none

package plc_pkg;

   // Entry length default.
   localparam int CODE_LENGTH_DEF = 5;

   // Protocol bytes.
   localparam logic [7:0] READY_CODE     = 8'hF0;
   localparam logic [7:0] REPLY_MATCH    = 8'h0A;
   localparam logic [7:0] REPLY_MISMATCH = 8'h00;
   localparam logic [7:0] KEY_OPEN       = 8'h2B;  // '+'
   localparam logic [7:0] KEY_CHANGE     = 8'h2D;  // '-'

   // Item kinds.
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Phase codes.
   localparam int PHASE_W = 4;
   localparam logic [PHASE_W-1:0] PH_WAIT_FIRST    = 4'd0;
   localparam logic [PHASE_W-1:0] PH_FIRST_BYTES   = 4'd1;
   localparam logic [PHASE_W-1:0] PH_WAIT_CONFIRM  = 4'd2;
   localparam logic [PHASE_W-1:0] PH_CONFIRM_BYTES = 4'd3;
   localparam logic [PHASE_W-1:0] PH_MENU          = 4'd4;
   localparam logic [PHASE_W-1:0] PH_WAIT_LOGIN    = 4'd5;
   localparam logic [PHASE_W-1:0] PH_LOGIN_BYTES   = 4'd6;
   localparam logic [PHASE_W-1:0] PH_ALARM         = 4'd7;
   localparam logic [PHASE_W-1:0] PH_DOOR          = 4'd8;

   // Motor commands.
   localparam logic [1:0] MOTOR_STOP    = 2'd0;
   localparam logic [1:0] MOTOR_FORWARD = 2'd1;
   localparam logic [1:0] MOTOR_REVERSE = 2'd2;

   // Register map.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTEMPTS_ALLOWED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_TICKS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OPEN_TICKS       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TICKS       = 2'd3;

   localparam logic [2:0] ATTEMPTS_RESET = 3'd3;
   localparam logic [7:0] ALARM_RESET    = 8'd60;
   localparam logic [6:0] OPEN_RESET     = 7'd15;
   localparam logic [6:0] HOLD_RESET     = 7'd3;

   localparam int TICK_W = 9;

   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic               reply_valid;
      logic [7:0]         reply_byte;
      logic [1:0]         motor_cmd;
      logic               alarm_tone;
      logic [PHASE_W-1:0] phase_now;
   } rsp_type;

   typedef struct packed {
      logic [2:0] attempts_allowed;
      logic [7:0] alarm_ticks;
      logic [6:0] open_ticks;
      logic [6:0] hold_ticks;
   } cfg_type;

endpackage

`default_nettype wire

[src/plc_cfg_regs.sv]
`default_nettype none

module plc_cfg_regs (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_we,
   input  wire  [plc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [plc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output plc_pkg::cfg_type               cfg
);
   import plc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ATTEMPTS_ALLOWED: cfg_in.attempts_allowed = csr_wdata[2:0];
            CSR_ALARM_TICKS:      cfg_in.alarm_ticks      = csr_wdata[7:0];
            CSR_OPEN_TICKS:       cfg_in.open_ticks       = csr_wdata[6:0];
            CSR_HOLD_TICKS:       cfg_in.hold_ticks       = csr_wdata[6:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attempts_allowed <= ATTEMPTS_RESET;
         cfg_ff.alarm_ticks      <= ALARM_RESET;
         cfg_ff.open_ticks       <= OPEN_RESET;
         cfg_ff.hold_ticks       <= HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[src/plc_core.sv]
`default_nettype none
`include "assert_macros.svh"

module plc_core #(
   parameter int CODE_LENGTH = plc_pkg::CODE_LENGTH_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                fire,
   input  plc_pkg::req_type   item,
   input  plc_pkg::cfg_type   cfg,
   output plc_pkg::rsp_type   result
);
   import plc_pkg::*;

   localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODE_LENGTH - 1);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               mismatch_ff, mismatch_in;
   logic [2:0]         attempts_ff, attempts_in;
   logic               pending_open_ff, pending_open_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [1:0]         motor_ff, motor_in;

   // Stored password, no reset: always filled before it is compared.
   logic [7:0]         code_mem [CODE_LENGTH];
   logic               mem_we;
   logic [7:0]         mem_rd;

   logic               last_byte;
   logic               mismatch_now;
   logic [TICK_W-1:0]  tick_next;
   logic [TICK_W-1:0]  t1, t2, t3;
   logic               rvalid;
   logic [7:0]         rbyte;

   assign mem_rd       = code_mem[idx_ff];
   assign last_byte    = (idx_ff == LAST_IDX);
   assign mismatch_now = mismatch_ff | (mem_rd != item.rx_byte);
   assign tick_next    = tick_ff + TICK_W'(1);
   assign t1 = TICK_W'(cfg.open_ticks);
   assign t2 = TICK_W'(cfg.open_ticks) + TICK_W'(cfg.hold_ticks);
   assign t3 = t2 + TICK_W'(cfg.open_ticks);

   always_comb begin
      phase_in        = phase_ff;
      idx_in          = idx_ff;
      mismatch_in     = mismatch_ff;
      attempts_in     = attempts_ff;
      pending_open_in = pending_open_ff;
      tick_in         = tick_ff;
      motor_in        = motor_ff;
      mem_we          = 1'b0;
      rvalid          = 1'b0;
      rbyte           = REPLY_MISMATCH;

      if (item.op == OP_BYTE) begin
         unique case (phase_ff) inside
            PH_WAIT_FIRST, PH_WAIT_CONFIRM, PH_WAIT_LOGIN: begin
               if (item.rx_byte == READY_CODE) begin
                  idx_in      = '0;
                  mismatch_in = 1'b0;
                  phase_in    = phase_ff + PHASE_W'(1);
               end
            end
            PH_FIRST_BYTES: begin
               mem_we = 1'b1;
               if (last_byte) begin
                  idx_in   = '0;
                  phase_in = PH_WAIT_CONFIRM;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
            PH_CONFIRM_BYTES: begin
               mismatch_in = mismatch_now;
               if (last_byte) begin
                  idx_in = '0;
                  rvalid = 1'b1;
                  if (mismatch_now) begin
                     rbyte    = REPLY_MISMATCH;
                     phase_in = PH_WAIT_FIRST;
                  end else begin
                     rbyte    = REPLY_MATCH;
                     phase_in = PH_MENU;
                  end
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
            PH_MENU: begin
               if (item.rx_byte == KEY_OPEN || item.rx_byte == KEY_CHANGE) begin
                  pending_open_in = (item.rx_byte == KEY_OPEN);
                  attempts_in     = cfg.attempts_allowed;
                  phase_in        = PH_WAIT_LOGIN;
               end
            end
            PH_LOGIN_BYTES: begin
               mismatch_in = mismatch_now;
               if (last_byte) begin
                  idx_in = '0;
                  rvalid = 1'b1;
                  if (mismatch_now) begin
                     rbyte = REPLY_MISMATCH;
                     if (attempts_ff <= 3'd1) begin
                        attempts_in = '0;
                        tick_in     = '0;
                        phase_in    = PH_ALARM;
                     end else begin
                        attempts_in = attempts_ff - 3'd1;
                        phase_in    = PH_WAIT_LOGIN;
                     end
                  end else begin
                     rbyte = REPLY_MATCH;
                     if (pending_open_ff) begin
                        tick_in  = '0;
                        motor_in = MOTOR_FORWARD;
                        phase_in = PH_DOOR;
                     end else begin
                        phase_in = PH_WAIT_FIRST;
                     end
                  end
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
            default: begin
               // drop bytes in alarm and door
            end
         endcase
      end else begin
         if (phase_ff == PH_ALARM) begin
            tick_in = tick_next;
            if (tick_next > TICK_W'(cfg.alarm_ticks)) phase_in = PH_MENU;
         end else if (phase_ff == PH_DOOR) begin
            tick_in = tick_next;
            if (tick_next >= t3) begin
               motor_in = MOTOR_STOP;
               phase_in = PH_MENU;
            end else if (tick_next >= t2) begin
               motor_in = MOTOR_REVERSE;
            end else if (tick_next >= t1) begin
               motor_in = MOTOR_STOP;
            end else begin
               motor_in = MOTOR_FORWARD;
            end
         end
      end
   end

   always_comb begin
      result.reply_valid = rvalid;
      result.reply_byte  = rbyte;
      result.motor_cmd   = motor_in;
      result.alarm_tone  = (phase_in == PH_ALARM) && tick_in[0];
      result.phase_now   = phase_in;
   end

   always_ff @(posedge clock) begin
      if (fire && mem_we) begin
         code_mem[idx_ff] <= item.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_WAIT_FIRST;
         idx_ff          <= '0;
         mismatch_ff     <= 1'b0;
         attempts_ff     <= ATTEMPTS_RESET;
         pending_open_ff <= 1'b0;
         tick_ff         <= '0;
         motor_ff        <= MOTOR_STOP;
      end else if (fire) begin
         phase_ff        <= phase_in;
         idx_ff          <= idx_in;
         mismatch_ff     <= mismatch_in;
         attempts_ff     <= attempts_in;
         pending_open_ff <= pending_open_in;
         tick_ff         <= tick_in;
         motor_ff        <= motor_in;
      end
   end

   `PLC_ASSERT(a_reply_from_entry, clock, reset, result.reply_valid |-> (item.op == OP_BYTE && (phase_ff == PH_CONFIRM_BYTES || phase_ff == PH_LOGIN_BYTES) && last_byte), "reply without a completed compared entry")
   `PLC_ASSERT(a_motor_only_in_door, clock, reset, (motor_ff != MOTOR_STOP) |-> (phase_ff == PH_DOOR), "motor running outside door phase")
   `PLC_ASSERT(a_alarm_no_attempts, clock, reset, (phase_ff == PH_ALARM) |-> (attempts_ff == 3'd0), "alarm with attempts left")
   `PLC_ASSERT(a_idle_holds_state, clock, reset, !fire |=> ($stable(phase_ff) && $stable(idx_ff) && $stable(tick_ff)), "state moved without a transaction")

endmodule

`default_nettype wire

[src/password_lock_controller_unit.sv]
`default_nettype none

// Channel  | Ports                          | Direction | Transfer
// ---------+--------------------------------+-----------+-------------------------
// request  | req_valid, req_ready, req_data | in        | valid & ready at clock
// response | rsp_valid, rsp_ready, rsp_data | out       | valid & ready at clock
// csr      | csr_we, csr_index, csr_wdata   | in        | csr_we at clock, no wait
//
// Every request transaction yields exactly one response transaction.
// A request passes through the input register, then the result register.
// Throughput is one transaction per cycle while rsp_ready stays high.
// Reset (synchronous, active high) empties both registers and restores phase and CSRs.
// A stalled response holds the result register; the input register keeps accepting
// while the result register is free or being drained in the same cycle.

module password_lock_controller_unit #(
   parameter int CODE_LENGTH = plc_pkg::CODE_LENGTH_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  plc_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output plc_pkg::rsp_type               rsp_data,
   input  wire                            csr_we,
   input  wire  [plc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [plc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import plc_pkg::*;

   // Input register
   req_type req_ff;
   logic    req_valid_ff;

   // Result register
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   cfg_type cfg;
   rsp_type core_result;
   logic    fire;

   // Advance the held transaction when the result register is empty or draining.
   assign fire      = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || fire;

   plc_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   plc_core #(
      .CODE_LENGTH (CODE_LENGTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (req_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   // Capture a new request whenever the input register frees up.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
   end

   // Load the result on fire, drop it once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[dv/lock_response_checker.sv]
`timescale 1ns / 1ps

module lock_response_checker (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   input  wire                            req_ready,
   input  plc_pkg::req_type               req_data,
   input  wire                            rsp_valid,
   input  wire                            rsp_ready,
   input  plc_pkg::rsp_type               rsp_data,
   input  wire                            csr_we,
   input  wire  [plc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [plc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_total,
   output int                             expected_left
);
   import plc_pkg::*;

   // register copies
   logic [2:0] allowed_cfg;
   logic [7:0] alarm_cfg;
   logic [6:0] open_cfg;
   logic [6:0] hold_cfg;

   // lock state
   logic [PHASE_W-1:0] phase_q;
   logic [7:0]         stored_digits [CODE_LENGTH_DEF];
   logic [2:0]         digit_pos;
   logic               mismatch_seen;
   logic [2:0]         tries_left;
   logic               open_after_login;
   logic [TICK_W-1:0]  tick_count;
   logic [1:0]         motor_q;

   rsp_type predicted_outputs [$];
   int      mismatches = 0;

   assign fail_total = mismatches;

   task automatic open_entry(input logic [PHASE_W-1:0] next_phase);
      digit_pos     = '0;
      mismatch_seen = 1'b0;
      phase_q       = next_phase;
   endtask

   // Store or compare one password byte; flag when the entry is complete.
   task automatic take_digit(input logic [7:0] value, input logic store, output logic done);
      int pos;
      pos = digit_pos;
      if (pos >= CODE_LENGTH_DEF) pos = 0;
      if (store) stored_digits[pos] = value;
      else if (stored_digits[pos] != value) mismatch_seen = 1'b1;
      pos++;
      done      = (pos >= CODE_LENGTH_DEF);
      digit_pos = done ? 3'd0 : 3'(pos);
   endtask

   task automatic advance_lock(input req_type item, output rsp_type res);
      logic done;
      int   t1, t2, t3;
      res = '0;
      if (item.op == OP_BYTE) begin
         case (phase_q)
            PH_WAIT_FIRST: begin
               if (item.rx_byte == READY_CODE) open_entry(PH_FIRST_BYTES);
            end
            PH_FIRST_BYTES: begin
               take_digit(item.rx_byte, 1'b1, done);
               if (done) phase_q = PH_WAIT_CONFIRM;
            end
            PH_WAIT_CONFIRM: begin
               if (item.rx_byte == READY_CODE) open_entry(PH_CONFIRM_BYTES);
            end
            PH_CONFIRM_BYTES: begin
               take_digit(item.rx_byte, 1'b0, done);
               if (done) begin
                  res.reply_valid = 1'b1;
                  res.reply_byte  = mismatch_seen ? REPLY_MISMATCH : REPLY_MATCH;
                  phase_q         = mismatch_seen ? PH_WAIT_FIRST : PH_MENU;
               end
            end
            PH_MENU: begin
               if (item.rx_byte == KEY_OPEN || item.rx_byte == KEY_CHANGE) begin
                  open_after_login = (item.rx_byte == KEY_OPEN);
                  tries_left       = allowed_cfg;
                  phase_q          = PH_WAIT_LOGIN;
               end
            end
            PH_WAIT_LOGIN: begin
               if (item.rx_byte == READY_CODE) open_entry(PH_LOGIN_BYTES);
            end
            PH_LOGIN_BYTES: begin
               take_digit(item.rx_byte, 1'b0, done);
               if (done) begin
                  res.reply_valid = 1'b1;
                  if (mismatch_seen) begin
                     res.reply_byte = REPLY_MISMATCH;
                     if (tries_left <= 3'd1) begin
                        tries_left = '0;
                        tick_count = '0;
                        phase_q    = PH_ALARM;
                     end else begin
                        tries_left = tries_left - 3'd1;
                        phase_q    = PH_WAIT_LOGIN;
                     end
                  end else begin
                     res.reply_byte = REPLY_MATCH;
                     if (open_after_login) begin
                        tick_count = '0;
                        motor_q    = MOTOR_FORWARD;
                        phase_q    = PH_DOOR;
                     end else begin
                        phase_q = PH_WAIT_FIRST;
                     end
                  end
               end
            end
            default: ;
         endcase
      end else if (phase_q == PH_ALARM) begin
         tick_count = tick_count + 1'b1;
         if (tick_count > alarm_cfg) phase_q = PH_MENU;
      end else if (phase_q == PH_DOOR) begin
         t1 = open_cfg;
         t2 = t1 + int'(hold_cfg);
         t3 = t2 + t1;
         tick_count = tick_count + 1'b1;
         if (int'(tick_count) >= t3) begin
            motor_q = MOTOR_STOP;
            phase_q = PH_MENU;
         end else if (int'(tick_count) >= t2) begin
            motor_q = MOTOR_REVERSE;
         end else if (int'(tick_count) >= t1) begin
            motor_q = MOTOR_STOP;
         end else begin
            motor_q = MOTOR_FORWARD;
         end
      end
      res.motor_cmd  = motor_q;
      res.alarm_tone = (phase_q == PH_ALARM) && tick_count[0];
      res.phase_now  = phase_q;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type predicted;
      rsp_type oldest;
      if (reset) begin
         allowed_cfg      = ATTEMPTS_RESET;
         alarm_cfg        = ALARM_RESET;
         open_cfg         = OPEN_RESET;
         hold_cfg         = HOLD_RESET;
         phase_q          = PH_WAIT_FIRST;
         foreach (stored_digits[i]) stored_digits[i] = '0;
         digit_pos        = '0;
         mismatch_seen    = 1'b0;
         tries_left       = ATTEMPTS_RESET;
         open_after_login = 1'b0;
         tick_count       = '0;
         motor_q          = MOTOR_STOP;
         predicted_outputs.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ATTEMPTS_ALLOWED: allowed_cfg = csr_wdata[2:0];
               CSR_ALARM_TICKS:      alarm_cfg   = csr_wdata;
               CSR_OPEN_TICKS:       open_cfg    = csr_wdata[6:0];
               CSR_HOLD_TICKS:       hold_cfg    = csr_wdata[6:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            advance_lock(req_data, predicted);
            predicted_outputs.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_outputs.size() == 0) begin
               $error("response transaction with no prediction pending (phase_now %0d)",
                      rsp_data.phase_now);
               mismatches++;
            end else begin
               oldest = predicted_outputs.pop_front();
               check_field("reply_valid", oldest.reply_valid, rsp_data.reply_valid);
               check_field("reply_byte", oldest.reply_byte, rsp_data.reply_byte);
               check_field("motor_cmd", oldest.motor_cmd, rsp_data.motor_cmd);
               check_field("alarm_tone", oldest.alarm_tone, rsp_data.alarm_tone);
               check_field("phase_now", oldest.phase_now, rsp_data.phase_now);
            end
         end
      end
      expected_left <= predicted_outputs.size();
   end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import plc_pkg::*;

   typedef logic [CODE_LENGTH_DEF-1:0][7:0] code_type;

   // Where in the lock's flow an ignored transaction is being slipped in.
   typedef enum int {SPOT_WAIT, SPOT_ENTRY, SPOT_MENU, SPOT_TIMED} spot_type;

   // Response-side back-pressure styles.
   typedef enum int {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_type;

   localparam int ITEM_TARGET = 1950;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_total;
   int expected_left;

   // Stimulus bookkeeping: the current password and register values, so that
   // the generated sequences land where they are meant to.
   code_type secret;
   int tries_cfg = ATTEMPTS_RESET;
   int alarm_cfg = ALARM_RESET;
   int open_cfg  = OPEN_RESET;
   int hold_cfg  = HOLD_RESET;

   int burst_left     = 0;
   int items_sent     = 0;
   int ignored_sent   = 0;
   int settings_used  = 0;
   int passwords_set  = 0;
   int alarms_run     = 0;
   int doors_run      = 0;
   int phase_runs     = 0;

   stall_type stall_mode = STALL_NONE;
   int        stall_left = 0;

   password_lock_controller_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lock_response_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_total    (fail_total),
      .expected_left (expected_left)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard stop in case the block wedges; far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("password_lock_controller_unit regression: fail");
      $finish;
   end

   // Receiver: pick a stall style for a random stretch, then switch. The
   // no-stall style gives long runs of back-to-back drains.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_type'($urandom_range(0, 3));
         stall_left = $urandom_range(10, 80);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE:  rsp_ready <= 1'b1;
         STALL_COIN:  rsp_ready <= 1'($urandom_range(0, 1));
         STALL_HEAVY: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:     rsp_ready <= (stall_left % 4 != 0);
      endcase
   end

   // Offer one transaction and hold it until accepted. Bursts of random length
   // are separated by random gaps; about a quarter of the bursts start with no
   // gap at all.
   task automatic send_item(input logic op, input logic [7:0] value);
      req_type item;
      int      gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      item.op      = op;
      item.rx_byte = value;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Now and then slip in transactions the lock must ignore at this spot.
   task automatic ignored_items(input spot_type where);
      logic [7:0] value;
      int         count;
      if ($urandom_range(0, 4) != 0) return;
      count = $urandom_range(1, 2);
      repeat (count) begin
         value = 8'($urandom());
         if (where == SPOT_ENTRY || (where != SPOT_TIMED && $urandom_range(0, 1) == 0)) begin
            send_item(OP_TICK, value);
         end else begin
            while ((where == SPOT_WAIT && value == READY_CODE) ||
                   (where == SPOT_MENU && (value == KEY_OPEN || value == KEY_CHANGE)))
               value = 8'($urandom());
            send_item(OP_BYTE, value);
         end
         ignored_sent++;
      end
   endtask

   // Ready code, then the password bytes; ticks may fall in between.
   task automatic send_entry(input code_type digits);
      ignored_items(SPOT_WAIT);
      send_item(OP_BYTE, READY_CODE);
      for (int i = 0; i < CODE_LENGTH_DEF; i++) begin
         ignored_items(SPOT_ENTRY);
         send_item(OP_BYTE, digits[i]);
      end
   endtask

   // Bias digits toward the protocol bytes and the byte extremes.
   function automatic code_type random_code();
      code_type digits;
      for (int i = 0; i < CODE_LENGTH_DEF; i++) begin
         case ($urandom_range(0, 9))
            0:       digits[i] = READY_CODE;
            1:       digits[i] = KEY_OPEN;
            2:       digits[i] = KEY_CHANGE;
            3:       digits[i] = 8'h00;
            4:       digits[i] = 8'hFF;
            default: digits[i] = 8'($urandom());
         endcase
      end
      return digits;
   endfunction

   // Flip at least one bit of one digit so the entry can never match.
   function automatic code_type garble(input code_type digits);
      int pos;
      pos = $urandom_range(0, CODE_LENGTH_DEF - 1);
      digits[pos] = digits[pos] ^ 8'($urandom_range(1, 255));
      return digits;
   endfunction

   // Drop valid, let every prediction drain, then let the pipeline idle
   // before touching the registers or ending.
   task automatic settle_block;
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_left != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic load_settings(input int tries, input int alarm, input int open, input int hold);
      settle_block();
      write_reg(CSR_ATTEMPTS_ALLOWED, tries);
      write_reg(CSR_ALARM_TICKS, alarm);
      write_reg(CSR_OPEN_TICKS, open);
      write_reg(CSR_HOLD_TICKS, hold);
      tries_cfg = tries;
      alarm_cfg = alarm;
      open_cfg  = open;
      hold_cfg  = hold;
      settings_used++;
   endtask

   // Feed ticks through a timed phase; stray bytes there are ignored.
   task automatic run_ticks(input int count);
      repeat (count) begin
         ignored_items(SPOT_TIMED);
         send_item(OP_TICK, 8'($urandom()));
      end
   endtask

   // Two-pass password setting; a spoiled confirmation starts it over.
   task automatic new_password;
      code_type attempt;
      logic     confirmed;
      passwords_set++;
      do begin
         attempt = random_code();
         send_entry(attempt);
         confirmed = ($urandom_range(0, 3) != 0);
         send_entry(confirmed ? attempt : garble(attempt));
      end while (!confirmed);
      secret = attempt;
   endtask

   // From the menu: request a login, miss some tries, and either trip the
   // alarm or get in and open the door or change the password.
   task automatic run_login(input logic want_open);
      int limit;
      int wrong;
      int door_len;
      ignored_items(SPOT_MENU);
      send_item(OP_BYTE, want_open ? KEY_OPEN : KEY_CHANGE);
      limit = (tries_cfg == 0) ? 1 : tries_cfg;
      wrong = ($urandom_range(0, 3) == 0) ? limit : $urandom_range(0, limit - 1);
      repeat (wrong) send_entry(garble(secret));
      if (wrong == limit) begin
         alarms_run++;
         run_ticks(alarm_cfg + 1);
      end else begin
         send_entry(secret);
         if (want_open) begin
            doors_run++;
            door_len = 2 * open_cfg + hold_cfg;
            run_ticks((door_len == 0) ? 1 : door_len);
         end else begin
            new_password();
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: ignored tick and byte while waiting, a password holding the
      // ready code and both byte extremes, then zero attempts, zero alarm time
      // and zero door times, with a byte dropped during the alarm.
      settings_used = 1;
      send_item(OP_TICK, 8'hA5);
      send_item(OP_BYTE, 8'h00);
      secret = {8'hFF, READY_CODE, 8'h00, KEY_OPEN, KEY_CHANGE};
      send_entry(secret);
      send_entry(secret);
      passwords_set++;
      load_settings(0, 0, 0, 0);
      send_item(OP_BYTE, KEY_OPEN);
      send_entry(garble(secret));
      alarms_run++;
      send_item(OP_BYTE, KEY_CHANGE);
      send_item(OP_TICK, 8'h00);
      send_item(OP_BYTE, KEY_OPEN);
      send_entry(secret);
      doors_run++;
      send_item(OP_TICK, 8'hFF);

      // Random sequences, several register settings; the first one pins
      // every register at its top value, later ones mostly stay small.
      while (items_sent < ITEM_TARGET) begin
         if (phase_runs == 0) begin
            if (settings_used == 2) begin
               load_settings(7, 255, 127, 127);
               phase_runs = 2;
            end else begin
               load_settings($urandom_range(0, 7),
                             ($urandom_range(0, 9) == 0) ? 0 :
                             ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(1, 24),
                             ($urandom_range(0, 9) == 0) ? 0 :
                             ($urandom_range(0, 9) == 0) ? 127 : $urandom_range(1, 12),
                             ($urandom_range(0, 9) == 0) ? 127 : $urandom_range(0, 8));
               phase_runs = $urandom_range(4, 10);
            end
         end
         phase_runs--;
         case ($urandom_range(0, 9))
            0: begin
               repeat ($urandom_range(1, 3)) begin
                  ignored_items(SPOT_MENU);
               end
            end
            1, 2, 3: run_login(1'b0);
            default: run_login(1'b1);
         endcase
      end
      settle_block();

      $display("Sent %0d transactions (%0d of them ignored noise) under %0d register settings.",
               items_sent, ignored_sent, settings_used);
      $display("Covered %0d password settings, %0d alarm runs and %0d door cycles.",
               passwords_set, alarms_run, doors_run);
      if (fail_total == 0) begin
         $display("password_lock_controller_unit regression: pass");
      end else begin
         $display("password_lock_controller_unit regression: fail");
      end
      $finish;
   end

endmodule
